>>> rtl/core/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Shared types, constants and codes of the session packet rate limiter.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int SESSION_SLOTS = 256;
  localparam int SLOT_W        = 8;
  localparam int TICK_W        = 32;
  localparam int CNT_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // item operation codes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_CLOSE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKETS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE_PACKETS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROPS        = 2'd3;

  localparam logic [TICK_W-1:0] WINDOW_TICKS_RST     = 32'd1000;
  localparam logic [CNT_W-1:0]  MAX_PACKETS_RST      = 16'd60;
  localparam logic [CNT_W-1:0]  MAX_MOVE_PACKETS_RST = 16'd40;
  localparam logic [CNT_W-1:0]  MAX_DROPS_RST        = 16'd20;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [TICK_W-1:0] window_ticks;
    logic [CNT_W-1:0]  max_packets;
    logic [CNT_W-1:0]  max_move_packets;
    logic [CNT_W-1:0]  max_drops;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    slot_t             session_slot;
    logic              is_move_input;
    logic [TICK_W-1:0] now_ticks;
  } item_t;

  // per-slot record held in memory
  typedef struct packed {
    logic [TICK_W-1:0] window_start;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  move_count;
    logic [CNT_W-1:0]  drop_count;
  } entry_t;

  // write-back of one item to the slot table
  typedef struct packed {
    logic   en;
    logic   close;
    slot_t  slot;
    entry_t entry;
  } upd_t;

  typedef struct packed {
    logic accept;
    logic disconnect_request;
  } result_t;

endpackage

>>> rtl/core/srl_if.sv
// ----------------------------------------------------------------------------
// srl_in_if / srl_out_if
// Valid/ready channels for policed items and their verdicts.
// ----------------------------------------------------------------------------
interface srl_in_if;
  import srl_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  slot_t             session_slot;
  logic              is_move_input;
  logic [TICK_W-1:0] now_ticks;

  modport source (output valid, operation, session_slot, is_move_input, now_ticks,
                  input ready);
  modport sink   (input valid, operation, session_slot, is_move_input, now_ticks,
                  output ready);
endinterface

interface srl_out_if;
  logic valid;
  logic ready;
  logic accept;
  logic disconnect_request;

  modport source (output valid, accept, disconnect_request, input ready);
  modport sink   (input valid, accept, disconnect_request, output ready);
endinterface

>>> rtl/core/srl_state_mem.sv
// ----------------------------------------------------------------------------
// srl_state_mem
// Slot table: registered-read memory of per-slot records, valid flops and a
// bypass of the most recent write.
// ----------------------------------------------------------------------------
module srl_state_mem (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  srl_pkg::slot_t rd_slot,
  input  srl_pkg::slot_t lookup_slot,
  input  srl_pkg::upd_t  upd,
  output srl_pkg::entry_t rd_entry,
  output logic           rd_valid
);
  import srl_pkg::*;

  entry_t mem [SESSION_SLOTS];
  entry_t rd_data_r;

  logic [SESSION_SLOTS-1:0] slot_valid_r;

  logic   wr_valid_r;
  slot_t  wr_slot_r;
  entry_t wr_data_r;

  always_ff @(posedge clk) begin
    if (upd.en && !upd.close) begin
      mem[upd.slot] <= upd.entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  // last write, for a read issued on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else if (upd.en && !upd.close) begin
      wr_valid_r <= 1'b1;
    end
    if (upd.en && !upd.close) begin
      wr_slot_r <= upd.slot;
      wr_data_r <= upd.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (upd.en) begin
      slot_valid_r[upd.slot] <= !upd.close;
    end
  end

  assign rd_entry = (wr_valid_r && wr_slot_r == lookup_slot) ? wr_data_r : rd_data_r;
  assign rd_valid = slot_valid_r[lookup_slot];

endmodule

>>> rtl/core/srl_policer.sv
// ----------------------------------------------------------------------------
// srl_policer
// Window check, budget compare and counter update for one item.
// ----------------------------------------------------------------------------
module srl_policer (
  input  srl_pkg::cfg_t    cfg,
  input  srl_pkg::item_t   item,
  input  logic             item_valid,
  input  srl_pkg::entry_t  cur,
  input  logic             cur_valid,
  output srl_pkg::upd_t    upd,
  output srl_pkg::result_t res
);
  import srl_pkg::*;

  logic [TICK_W-1:0] age;
  logic              reopen;
  entry_t            base;
  logic              tot_full;
  logic              move_full;
  logic [CNT_W-1:0]  drops_inc;

  always_comb begin
    age    = item.now_ticks - cur.window_start;
    reopen = !cur_valid || (age >= cfg.window_ticks);

    base = cur;
    if (reopen) begin
      base.window_start = item.now_ticks;
      base.total_count  = '0;
      base.move_count   = '0;
      base.drop_count   = '0;
    end

    tot_full  = base.total_count >= cfg.max_packets;
    move_full = item.is_move_input && (base.move_count >= cfg.max_move_packets);
    drops_inc = (base.drop_count == {CNT_W{1'b1}}) ? base.drop_count
                                                    : base.drop_count
                                                      + {{(CNT_W-1){1'b0}}, 1'b1};

    upd.en    = item_valid;
    upd.close = (item.operation == OP_CLOSE);
    upd.slot  = item.session_slot;
    upd.entry = base;
    res       = '0;

    if (item.operation == OP_PACKET) begin
      if (tot_full || move_full) begin
        upd.entry.drop_count   = drops_inc;
        res.disconnect_request = drops_inc > cfg.max_drops;
      end else begin
        upd.entry.total_count = base.total_count + {{(CNT_W-1){1'b0}}, 1'b1};
        upd.entry.move_count  = base.move_count + {{(CNT_W-1){1'b0}}, item.is_move_input};
        res.accept            = 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/session_packet_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// session_packet_rate_limiter_top
// Per-session fixed-window packet policer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one beat per item (packet arrival or session close) carrying
//            the session slot, a move-input flag and a tick timestamp.
//   out_if : one beat per item with the verdict (accept) and a disconnect
//            request. Close items answer accept=0, disconnect_request=0.
//   cfg_*  : plain write port, index 0 window_ticks, 1 max_packets,
//            2 max_move_packets, 3 max_drops; write only while idle.
// Timing:
//   One item per cycle sustained while out_if.ready is high. The slot read is
//   issued at the in beat; the item is registered into the update stage, and
//   update, write-back and the output register load when that stage advances.
//   Back-to-back items on the same slot are served by a write bypass.
// Reset:
//   All slots go invalid at once (valid flops), registers take their
//   defaults; no clearing pass is needed.
// Stall:
//   When out_if.ready is low with a result pending, the item in the update
//   stage holds and in_if.ready drops until the output register frees.
// ----------------------------------------------------------------------------
module session_packet_rate_limiter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  srl_in_if.sink                            in_if,
  srl_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [srl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import srl_pkg::*;

  cfg_t    cfg_r;
  logic    adv;
  logic    in_beat;

  // update stage
  logic    p1_valid_r;
  item_t   p1_item_r;
  item_t   in_item;

  entry_t  cur_entry;
  logic    cur_valid;
  upd_t    upd;
  result_t res;

  // output register
  logic    out_valid_r;
  result_t out_res_r;

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks     <= WINDOW_TICKS_RST;
      cfg_r.max_packets      <= MAX_PACKETS_RST;
      cfg_r.max_move_packets <= MAX_MOVE_PACKETS_RST;
      cfg_r.max_drops        <= MAX_DROPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_TICKS:     cfg_r.window_ticks     <= cfg_wdata;
        CFG_MAX_PACKETS:      cfg_r.max_packets      <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_MOVE_PACKETS: cfg_r.max_move_packets <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_DROPS:        cfg_r.max_drops        <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- flow control: the update stage moves whenever the output slot frees
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;
  assign in_beat     = in_if.valid && adv;

  assign in_item.operation     = in_if.operation;
  assign in_item.session_slot  = in_if.session_slot;
  assign in_item.is_move_input = in_if.is_move_input;
  assign in_item.now_ticks     = in_if.now_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= in_beat;
    end
    if (in_beat) begin
      p1_item_r <= in_item;
    end
  end

  // ---- slot table, read on the input beat
  srl_state_mem u_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_beat),
    .rd_slot     (in_if.session_slot),
    .lookup_slot (p1_item_r.session_slot),
    .upd         (upd),
    .rd_entry    (cur_entry),
    .rd_valid    (cur_valid)
  );

  // ---- read-modify-write; write-back only when the stage advances
  srl_policer u_policer (
    .cfg        (cfg_r),
    .item       (p1_item_r),
    .item_valid (p1_valid_r && adv),
    .cur        (cur_entry),
    .cur_valid  (cur_valid),
    .upd        (upd),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p1_valid_r;
    end
    if (adv && p1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.accept             = out_res_r.accept;
  assign out_if.disconnect_request = out_res_r.disconnect_request;

endmodule

>>> sim/session_packet_rate_limiter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_packet_rate_limiter_top_test
// Self-checking bench for the per-session fixed-window packet policer.
// A behavioral policer built into the bench tracks every slot. Each accepted
// input beat queues its predicted verdict. Each output beat is compared with
// the oldest queued verdict. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module session_packet_rate_limiter_top_test;
  import srl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // beat -> read -> update -> output register, plus margin
  localparam int unsigned IDLE_TAIL   = 4;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  srl_in_if  in_if ();
  srl_out_if out_if ();

  session_packet_rate_limiter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the policer: configuration and per-slot window state.
  // Slot entries other than slot_live only matter while the slot is live.
  // --------------------------------------------------------------------------
  cfg_t              limits;
  bit                slot_live [SESSION_SLOTS];
  logic [TICK_W-1:0] win_start [SESSION_SLOTS];
  logic [CNT_W-1:0]  pkt_cnt   [SESSION_SLOTS];
  logic [CNT_W-1:0]  move_cnt  [SESSION_SLOTS];
  logic [CNT_W-1:0]  drop_cnt  [SESSION_SLOTS];

  result_t           verdicts_due [$];   // predicted verdicts, oldest first
  int unsigned       fail_count = 0;
  int unsigned       cycles_run = 0;

  // idling knobs, in percent per beat; zero gives a stretch with no idling
  int unsigned       gap_pct   = 0;
  int unsigned       stall_pct = 0;

  // running timestamp used by the traffic generator
  logic [TICK_W-1:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycles_run <= cycles_run + 1;

  // hard stop if the pipeline hangs or a verdict never shows up
  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Predict the verdict for one accepted beat and advance the slot state.
  function automatic result_t police_item(input item_t it);
    result_t           verdict;
    slot_t             s;
    logic [TICK_W-1:0] age;
    verdict = '0;
    s       = it.session_slot;
    if (it.operation == OP_CLOSE) begin
      slot_live[s] = 1'b0;
      return verdict;
    end
    // wrapping age of the window; only meaningful on a live slot
    age = it.now_ticks - win_start[s];
    // fresh slot or run-out window: window restarts now, counters clear.
    // A zero-length window restarts on every packet.
    if (!slot_live[s] || age >= limits.window_ticks) begin
      slot_live[s] = 1'b1;
      win_start[s] = it.now_ticks;
      pkt_cnt[s]   = '0;
      move_cnt[s]  = '0;
      drop_cnt[s]  = '0;
    end
    // count + 1 > limit is the same as count >= limit at these widths
    if (pkt_cnt[s] >= limits.max_packets ||
        (it.is_move_input && move_cnt[s] >= limits.max_move_packets)) begin
      // drop counter saturates; disconnect repeats while over the limit
      if (drop_cnt[s] != '1) drop_cnt[s] = drop_cnt[s] + CNT_W'(1);
      verdict.disconnect_request = (drop_cnt[s] > limits.max_drops);
    end else begin
      pkt_cnt[s] = pkt_cnt[s] + CNT_W'(1);
      if (it.is_move_input) move_cnt[s] = move_cnt[s] + CNT_W'(1);
      verdict.accept = 1'b1;
    end
    return verdict;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the verdict check.
  // Values read right after the edge are the ones the edge sampled.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    result_t     want;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict beat with no item outstanding");
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_if.accept !== want.accept) begin
            $error("accept: expected %0b, actual %0b", want.accept, out_if.accept);
            fail_count++;
          end
          if (out_if.disconnect_request !== want.disconnect_request) begin
            $error("disconnect_request: expected %0b, actual %0b",
                   want.disconnect_request, out_if.disconnect_request);
            fail_count++;
          end
        end
      end
      // mostly short stalls, now and then a long one
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(1, 3);
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // Offer one beat, wait for the handshake, queue its verdict, maybe idle.
  // Valid stays high when no gap follows, so back-to-back beats never
  // lower and raise valid in one step.
  task automatic send_item(input item_t it);
    int unsigned gap;
    in_if.valid         <= 1'b1;
    in_if.operation     <= it.operation;
    in_if.session_slot  <= it.session_slot;
    in_if.is_move_input <= it.is_move_input;
    in_if.now_ticks     <= it.now_ticks;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    verdicts_due = {verdicts_due, police_item(it)};
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet(input slot_t s, input logic mv, input logic [TICK_W-1:0] t);
    item_t it;
    it = '{operation: OP_PACKET, session_slot: s, is_move_input: mv, now_ticks: t};
    send_item(it);
  endtask

  task automatic send_close(input slot_t s);
    item_t it;
    it = '{operation: OP_CLOSE, session_slot: s, is_move_input: 1'b1,
           now_ticks: $urandom};
    send_item(it);
  endtask

  // Stop offering beats and let every verdict drain out of the pipeline.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Write all four registers back to back with the write enable held high.
  task automatic set_limits(input logic [TICK_W-1:0] win, input logic [CNT_W-1:0] pkts,
                            input logic [CNT_W-1:0] moves, input logic [CNT_W-1:0] drops);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_TICKS;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_index <= CFG_MAX_PACKETS;
    cfg_wdata <= {{(CFG_DATA_W-CNT_W){1'b0}}, pkts};
    @(posedge clk);
    cfg_index <= CFG_MAX_MOVE_PACKETS;
    cfg_wdata <= {{(CFG_DATA_W-CNT_W){1'b0}}, moves};
    @(posedge clk);
    cfg_index <= CFG_MAX_DROPS;
    cfg_wdata <= {{(CFG_DATA_W-CNT_W){1'b0}}, drops};
    @(posedge clk);
    cfg_we <= 1'b0;
    limits = '{window_ticks: win, max_packets: pkts, max_move_packets: moves,
               max_drops: drops};
  endtask

  // Traffic over a small pool of slots so the counters actually hit their
  // limits. odd_pct mixes in closes and noise beats: a stray slot or a
  // random timestamp that may jump backward and force a window restart.
  task automatic run_traffic(input int unsigned n_items, input int unsigned n_slots,
                             input int unsigned max_step, input int unsigned odd_pct);
    slot_t       pool [8];
    item_t       it;
    int unsigned k;
    int unsigned r;
    for (k = 0; k < 8; k++) pool[k] = slot_t'($urandom);
    for (k = 0; k < n_items; k++) begin
      tick_now         = tick_now + $urandom_range(0, max_step);
      it.operation     = OP_PACKET;
      it.session_slot  = pool[$urandom_range(0, n_slots - 1)];
      it.is_move_input = 1'($urandom_range(0, 1));
      it.now_ticks     = tick_now;
      r = $urandom_range(0, 99);
      if (r < odd_pct / 2) begin
        it.operation = OP_CLOSE;
        it.now_ticks = $urandom;
      end else if (r < odd_pct) begin
        if ($urandom_range(0, 1)) it.session_slot = slot_t'($urandom);
        else it.now_ticks = $urandom;
      end
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset defaults (1000 / 60 / 40 / 20) before any register write: one busy
  // slot runs through the total and drop limits.
  task automatic test_default_limits();
    gap_pct   = 10;
    stall_pct = 10;
    tick_now  = $urandom;
    run_traffic(100, 1, 3, 0);
  endtask

  // Small limits, hand-picked sequence: new slot, move limit, total limit,
  // disconnect repeat, window expiry, close and reopen, timestamp wrap.
  task automatic test_directed_basics();
    gap_pct   = 0;
    stall_pct = 0;
    set_limits(32'd100, 16'd3, 16'd2, 16'd1);
    send_packet(8'h00, 1'b1, 32'd10);           // opens the slot
    send_packet(8'h00, 1'b1, 32'd11);
    send_packet(8'h00, 1'b1, 32'd12);           // move budget spent
    send_packet(8'h00, 1'b0, 32'd13);
    send_packet(8'h00, 1'b0, 32'd14);           // total budget spent, disconnect
    send_packet(8'h00, 1'b1, 32'd15);           // disconnect again
    send_packet(8'h00, 1'b0, 32'd110);          // age exactly window: restart
    send_close(8'h00);
    send_packet(8'h00, 1'b1, 32'd111);          // reopened with fresh counters
    send_close(8'h80);                          // close of a slot never opened
    send_packet(8'hFF, 1'b0, 32'hFFFF_FFF0);
    send_packet(8'hFF, 1'b1, 32'h0000_0050);    // wrapped age 96, same window
    send_packet(8'hFF, 1'b0, 32'h0000_0054);    // wrapped age 100, restart
  endtask

  // Register extremes: zero window and zero limits, then the widest
  // window and limits, then a zero move budget under a wide total budget.
  task automatic test_limit_extremes();
    gap_pct   = 0;
    stall_pct = 0;
    set_limits(32'd0, 16'd0, 16'd0, 16'd0);
    send_packet(8'h5A, 1'b1, 32'd7);
    send_packet(8'h5A, 1'b0, 32'd7);
    send_packet(8'h5A, 1'b0, 32'hFFFF_FFFF);
    set_limits(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_packet(8'hA5, 1'b1, 32'h0000_0000);
    send_packet(8'hA5, 1'b0, 32'hFFFF_FFFE);
    send_packet(8'hA5, 1'b1, 32'hFFFF_FFFF);   // age equals window: restart
    set_limits(32'd1000, 16'hFFFF, 16'd0, 16'hFFFF);
    send_packet(8'h3C, 1'b1, 32'd500);
    send_packet(8'h3C, 1'b0, 32'd501);
  endtask

  // Zero budgets in one long window: every packet drops. Moving max_drops
  // across the running drop count turns the disconnect off and on again.
  task automatic test_drop_limit();
    int unsigned k;
    gap_pct   = 0;
    stall_pct = 0;
    set_limits(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd10);
    send_close(8'h69);                           // start from a fresh slot
    for (k = 0; k < 24; k++) send_packet(8'h69, k[0], 32'h1234_5678);
    set_limits(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd25);
    send_packet(8'h69, 1'b0, 32'h1234_5679);    // 25 drops, at the limit
    send_packet(8'h69, 1'b1, 32'h1234_567A);    // 26 drops, over it
    set_limits(32'hFFFF_FFFF, 16'd0, 16'd0, 16'hFFFF);
    send_packet(8'h69, 1'b0, 32'h1234_567B);
  endtask

  // Random phases, each with its own register setting and idling mix.
  task automatic test_random_phases();
    int unsigned      p;
    int unsigned      max_step;
    logic [TICK_W-1:0] win;
    logic [CNT_W-1:0]  mp;
    logic [CNT_W-1:0]  mm;
    logic [CNT_W-1:0]  md;
    for (p = 0; p < 10; p++) begin
      win = $urandom_range(1, 64);
      mp  = CNT_W'($urandom_range(0, 12));
      mm  = CNT_W'($urandom_range(0, 8));
      md  = CNT_W'($urandom_range(0, 6));
      case (p)
        0: begin
          win = 32'd1;
          mp  = 16'hFFFF;
          mm  = 16'hFFFF;
          md  = 16'hFFFF;
        end
        1: begin
          win = 32'hFFFF_FFFF;
          mm  = 16'd0;
          md  = 16'd0;
        end
        2: win = 32'd0;
        5: win = $urandom;
        default: ;
      endcase
      // p == 0 runs with no idling at all
      gap_pct   = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 45);
      stall_pct = (p % 4 == 0) ? 0 : ((p % 4 == 2) ? 45 : 15);
      // keep the per-beat time step small against the window so both
      // expiry and in-window bursts happen
      max_step  = (win == 0) ? 3 : ((win < 64) ? win / 3 + 1 : 20);
      set_limits(win, mp, mm, md);
      tick_now  = (p == 3) ? 32'hFFFF_FF80 : $urandom;   // phase 3 crosses the wrap
      run_traffic(120, $urandom_range(1, 6), max_step, 8);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned i;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_WINDOW_TICKS;
    cfg_wdata           <= '0;
    in_if.valid         <= 1'b0;
    in_if.operation     <= OP_PACKET;
    in_if.session_slot  <= '0;
    in_if.is_move_input <= 1'b0;
    in_if.now_ticks     <= '0;
    limits = '{window_ticks: WINDOW_TICKS_RST, max_packets: MAX_PACKETS_RST,
               max_move_packets: MAX_MOVE_PACKETS_RST, max_drops: MAX_DROPS_RST};
    for (i = 0; i < SESSION_SLOTS; i++) slot_live[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_limits();
    test_directed_basics();
    test_limit_extremes();
    test_drop_limit();
    test_random_phases();

    // all beats sent: drain, then let the pipeline idle before the final report
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
